/* hdl/upc_pkg.sv */
// Shared types, constants and character helpers for the URL percent codec.
package upc_pkg;

    localparam int UPC_FIFO_DEPTH = 4;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TILDE   = 8'h7E;
    localparam logic [7:0] CHAR_DASH    = 8'h2D;
    localparam logic [7:0] CHAR_UNDER   = 8'h5F;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] HEX_DIGIT_OFS  = 8'd48;
    localparam logic [7:0] HEX_LETTER_OFS = 8'd55;
    localparam logic [3:0] NIB_MASK       = 4'h0F;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // One queued command: either a single result or a three-byte escape.
    typedef struct packed {
        logic [7:0] data;
        logic       expand;
        logic       valid;
        logic       last;
        logic       error;
    } upc_cmd_t;

    function automatic logic [7:0] nib_to_ascii(input logic [3:0] n);
        logic [7:0] w;
        begin
            w = {4'b0000, n & NIB_MASK};
            nib_to_ascii = (n > 4'd9) ? w + HEX_LETTER_OFS : w + HEX_DIGIT_OFS;
        end
    endfunction

    // Bit 4 set means the character is a valid hex digit.
    function automatic logic [4:0] ascii_to_nib(input logic [7:0] c);
        logic [4:0] r;
        begin
            r = 5'b00000;
            if (c >= 8'h30 && c <= 8'h39)
                r = {1'b1, c[3:0]};
            else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                r = {1'b1, c[3:0] + 4'd9};
            ascii_to_nib = r;
        end
    endfunction

    function automatic logic passes_plain(input logic [7:0] c);
        begin
            passes_plain = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                           (c >= 8'h61 && c <= 8'h7A) || c == CHAR_DASH ||
                           c == CHAR_UNDER || c == CHAR_DOT || c == CHAR_TILDE;
        end
    endfunction

endpackage

/* hdl/upc_front.sv */
// Front end: accepts input bytes, tracks the decode escape state and queues commands.
module upc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mode_we,
    input  logic              mode_wdata,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last,
    output logic              cmd_push,
    output upc_pkg::upc_cmd_t cmd
);
    import upc_pkg::*;

    localparam logic [1:0] PH_PLAIN = 2'd0;
    localparam logic [1:0] PH_HIGH  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;

    logic       mode_reg;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] hi_reg, hi_next;
    logic       produce;
    logic [4:0] nib;

    always_comb
    begin
        nib        = ascii_to_nib(data_byte);
        phase_next = phase_reg;
        hi_next    = hi_reg;
        produce    = 1'b1;
        cmd.data   = data_byte;
        cmd.expand = 1'b0;
        cmd.valid  = 1'b1;
        cmd.last   = last;
        cmd.error  = 1'b0;
        if (mode_reg == MODE_ENCODE)
        begin
            phase_next = PH_PLAIN;
            if (passes_plain(data_byte))
                cmd.data = data_byte;
            else if (data_byte == CHAR_SPACE)
                cmd.data = CHAR_PLUS;
            else
                cmd.expand = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_HIGH, PH_LOW:
                begin
                    phase_next = PH_PLAIN;
                    if (!nib[4])
                    begin
                        cmd.data  = 8'h00;
                        cmd.valid = 1'b0;
                        cmd.error = 1'b1;
                    end
                    else if (phase_reg == PH_HIGH)
                    begin
                        hi_next = nib[3:0];
                        if (last)
                        begin
                            cmd.data  = 8'h00;
                            cmd.valid = 1'b0;
                            cmd.error = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LOW;
                            produce    = 1'b0;
                        end
                    end
                    else
                        cmd.data = {hi_reg, nib[3:0]};
                end
                default:
                begin
                    phase_next = PH_PLAIN;
                    if (data_byte == CHAR_PERCENT)
                    begin
                        if (last)
                        begin
                            cmd.data  = 8'h00;
                            cmd.valid = 1'b0;
                            cmd.error = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                            produce    = 1'b0;
                        end
                    end
                    else if (data_byte == CHAR_PLUS)
                        cmd.data = CHAR_SPACE;
                end
            endcase
        end
    end

    assign cmd_push = accept & produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_ENCODE;
            phase_reg <= PH_PLAIN;
            hi_reg    <= 4'h0;
        end
        else
        begin
            if (mode_we)
                mode_reg <= mode_wdata;
            if (accept)
            begin
                phase_reg <= phase_next;
                hi_reg    <= hi_next;
            end
        end
    end

endmodule

/* hdl/upc_fifo.sv */
// Short command queue between the front end and the output sequencer.
module upc_fifo #(
    parameter int Depth = upc_pkg::UPC_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  upc_pkg::upc_cmd_t wr_data,
    input  logic              rd_en,
    output upc_pkg::upc_cmd_t rd_data,
    output logic              full,
    output logic              empty
);
    import upc_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    upc_cmd_t        mem_reg [Depth];
    logic [PtrW-1:0] wptr_reg, rptr_reg;
    logic [CntW-1:0] cnt_reg;

    assign full    = (cnt_reg == FullCnt);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= (wptr_reg == LastPtr) ? '0 : wptr_reg + PtrW'(1);
            if (rd_en)
                rptr_reg <= (rptr_reg == LastPtr) ? '0 : rptr_reg + PtrW'(1);
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + CntW'(1);
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - CntW'(1);
        end
    end

endmodule

/* hdl/upc_back.sv */
// Back end: holds the current command and emits its one or three result items.
module upc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  upc_pkg::upc_cmd_t head,
    input  logic              head_empty,
    output logic              head_pop,
    input  logic              pop,
    output logic              empty,
    output logic [7:0]        out_byte,
    output logic              out_valid,
    output logic              out_last,
    output logic              error
);
    import upc_pkg::*;

    localparam logic [1:0] STEP_PCT = 2'd0;
    localparam logic [1:0] STEP_HI  = 2'd1;
    localparam logic [1:0] STEP_LO  = 2'd2;

    upc_cmd_t   cmd_reg;
    logic [1:0] step_reg;
    logic       busy_reg;
    logic       final_step;

    assign final_step = !cmd_reg.expand || step_reg == STEP_LO;
    assign empty      = !busy_reg;
    // Reload straight away when the final item of the current command leaves.
    assign head_pop   = !head_empty && (!busy_reg || (pop && final_step));

    always_comb
    begin
        out_valid = cmd_reg.valid;
        error     = cmd_reg.error;
        out_byte  = cmd_reg.data;
        out_last  = cmd_reg.last;
        if (cmd_reg.expand)
        begin
            out_last = cmd_reg.last && step_reg == STEP_LO;
            case (step_reg)
                STEP_PCT: out_byte = CHAR_PERCENT;
                STEP_HI:  out_byte = nib_to_ascii(cmd_reg.data[7:4]);
                default:  out_byte = nib_to_ascii(cmd_reg.data[3:0]);
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
            cmd_reg <= head;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= STEP_PCT;
        end
        else if (head_pop)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_PCT;
        end
        else if (busy_reg && pop)
        begin
            if (final_step)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + 2'd1;
        end
    end

endmodule

/* hdl/url_percent_codec_core.sv */
// Top level of the streaming URL form codec: front end, command queue and output sequencer.
//
// Streaming application/x-www-form-urlencoded codec, one byte per pushed item. The front end
// takes one byte per clock while the command queue (FifoDepth entries) has room, and the
// output sequencer delivers one result per clock while pop is held and results are queued.
// A byte that encodes to an escape yields three results; every other byte yields one, and a
// decoded escape prefix or first digit yields none. Write the mode register only while the
// block is idle; a pending escape is dropped when encoding.
module url_percent_codec_core #(
    parameter int FifoDepth = upc_pkg::UPC_FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_we,
    input  logic       mode_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       out_last,
    output logic       error
);
    import upc_pkg::*;

    upc_cmd_t cmd, head;
    logic     cmd_push, head_pop, head_empty, accept;

    assign accept = push && !full;

    upc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode_we    (mode_we),
        .mode_wdata (mode_wdata),
        .accept     (accept),
        .data_byte  (data_byte),
        .last       (last),
        .cmd_push   (cmd_push),
        .cmd        (cmd)
    );

    upc_fifo #(
        .Depth (FifoDepth)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (head_pop),
        .rd_data (head),
        .full    (full),
        .empty   (head_empty)
    );

    upc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .out_last   (out_last),
        .error      (error)
    );

endmodule
